// ===== design/timer_slot_pool_unit_assert.svh =====
// Assertion macros for the timer slot pool.
// Define NO_ASSERTIONS to compile them out.
`ifndef TIMER_SLOT_POOL_UNIT_ASSERT_SVH
`define TIMER_SLOT_POOL_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define TSP_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("timer_slot_pool_unit: same-cycle check failed");
`define TSP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("timer_slot_pool_unit: next-cycle check failed");
`else
`define TSP_ASSERT_IMPL(label, ante, cons)
`define TSP_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== design/tsp_pkg.sv =====
package tsp_pkg;

	localparam int SLOT_COUNT  = 32;
	localparam int QUEUE_COUNT = 4;
	localparam int MAX_RESULTS = 32;

	localparam int SIDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int SCNT_W = $clog2(SLOT_COUNT + 1);
	localparam int FCNT_W = $clog2(MAX_RESULTS + 1);
	localparam int DL_W   = 32;

	typedef enum logic [2:0] {
		OP_ALLOC       = 3'd0,
		OP_FREE        = 3'd1,
		OP_INIT        = 3'd2,
		OP_SET_TIMEOUT = 3'd3,
		OP_TICK        = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		KIND_ALLOC_OK   = 3'd0,
		KIND_ALLOC_NONE = 3'd1,
		KIND_ACK        = 3'd2,
		KIND_FIRED      = 3'd3,
		KIND_TICK_IDLE  = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		SS_FREE  = 2'd0,
		SS_ALLOC = 2'd1,
		SS_ARMED = 2'd2
	} slot_state_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ACK,
		ST_ALLOC,
		ST_TICK
	} fsm_t;

	typedef struct packed {
		logic [1:0] queue;
		logic [7:0] data;
	} slot_info_t;

	localparam int INFO_W = $bits(slot_info_t);

endpackage

// ===== design/timer_slot_pool_unit.sv =====
// Timer slot pool, one request in flight at a time; unknown opcodes are dropped without a result.
// Free, init, set timeout: the ack is pushed from the ack state once the result register is free.
// Alloc: walks the slots from 0 for the lowest free one and reports it, or none after the last slot.
// Tick: walks every slot via the registered RAM read; each fire is held until a newer fire or
// the walk end pushes it; the scan stalls while the result port is full and a new fire is due.
// Reset (arst_n low): tick counter zero, all slots free; slot memories are not cleared.
module timer_slot_pool_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  logic [2:0]  op,
	input  logic [4:0]  slot,
	input  logic [1:0]  queue_id,
	input  logic [7:0]  payload,
	input  logic [31:0] delay_ticks,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output logic [2:0]  kind,
	output logic [4:0]  slot_out,
	output logic [1:0]  queue_out,
	output logic [7:0]  data_out,
	output logic        last
);

	import tsp_pkg::*;

	// control and status
	fsm_t              state_q, state_nxt;
	logic [31:0]       tick_q;
	slot_state_t       status_q [SLOT_COUNT];
	logic [SCNT_W-1:0] scan_q;
	logic [FCNT_W-1:0] fire_cnt_q;
	logic              pend_valid_q;
	logic              rd_valid_s1;

	// payload registers
	logic [SIDX_W-1:0] rd_idx_s1;
	logic [SIDX_W-1:0] pend_idx_q;
	slot_info_t        pend_info_q;
	logic [4:0]        ack_slot_q;

	// result register
	logic              rsp_valid_q;
	kind_t             kind_q;
	logic [4:0]        slot_out_q;
	logic [1:0]        queue_out_q;
	logic [7:0]        data_out_q;
	logic              last_q;

	// request decode
	logic              req_fire;
	logic [SIDX_W-1:0] req_idx;
	logic              req_ok;
	logic [1:0]        queue_clamped;

	// scan helpers
	logic [SIDX_W-1:0] scan_idx;
	logic              scan_end;
	logic [SIDX_W-1:0] st_ridx;
	slot_state_t       st_rd;
	logic              out_free;
	logic              due;
	logic              adv;
	logic              tick_done;

	// memory ports
	logic [DL_W-1:0]   dl_rd;
	logic [INFO_W-1:0] info_rd_raw;
	slot_info_t        info_rd;
	slot_info_t        info_wr;
	logic              dl_we;
	logic              info_we;
	logic              ram_re;

	// status write port and result push
	logic              st_we;
	logic [SIDX_W-1:0] st_widx;
	slot_state_t       st_wval;
	logic              push;
	kind_t             push_kind;
	logic [4:0]        push_slot;
	logic [1:0]        push_queue;
	logic [7:0]        push_data;
	logic              push_last;

	assign req_ready     = (state_q == ST_IDLE);
	assign req_fire      = req_valid && req_ready;
	assign req_idx       = SIDX_W'(slot);
	assign req_ok        = int'(slot) < SLOT_COUNT;
	assign queue_clamped = (int'(queue_id) >= QUEUE_COUNT) ? 2'(QUEUE_COUNT - 1) : queue_id;
	assign info_wr       = '{queue: queue_clamped, data: payload};

	assign scan_idx  = scan_q[SIDX_W-1:0];
	assign scan_end  = (scan_q == SCNT_W'(SLOT_COUNT));
	assign out_free  = !rsp_valid_q || rsp_ready;

	// one status read port: walk index during alloc, pipeline index during tick
	assign st_ridx = (state_q == ST_ALLOC) ? scan_idx : rd_idx_s1;
	assign st_rd   = status_q[st_ridx];

	assign info_rd = slot_info_t'(info_rd_raw);

	// a slot is due when armed and its deadline is at or before the tick count; cap fires per tick
	assign due = (state_q == ST_TICK) && rd_valid_s1 && (st_rd == SS_ARMED) &&
		(dl_rd <= tick_q) && (fire_cnt_q != FCNT_W'(MAX_RESULTS));
	// hold the scan when a fired timer cannot hand the previous one to the result register
	assign adv       = !(due && pend_valid_q && !out_free);
	assign tick_done = scan_end && !rd_valid_s1;

	tsp_ram #(.WIDTH(DL_W), .DEPTH(SLOT_COUNT)) u_deadline_ram (
		.clk   (clk),
		.we    (dl_we),
		.waddr (req_idx),
		.wdata (delay_ticks + tick_q),
		.re    (ram_re),
		.raddr (scan_idx),
		.rdata (dl_rd)
	);

	tsp_ram #(.WIDTH(INFO_W), .DEPTH(SLOT_COUNT)) u_info_ram (
		.clk   (clk),
		.we    (info_we),
		.waddr (req_idx),
		.wdata (info_wr),
		.re    (ram_re),
		.raddr (scan_idx),
		.rdata (info_rd_raw)
	);

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_fire) begin
					unique case (op)
						OP_ALLOC:                        state_nxt = ST_ALLOC;
						OP_FREE, OP_INIT, OP_SET_TIMEOUT: state_nxt = ST_ACK;
						OP_TICK:                         state_nxt = ST_TICK;
						default:                         state_nxt = ST_IDLE;
					endcase
				end
			end
			ST_ACK: begin
				if (out_free) state_nxt = ST_IDLE;
			end
			ST_ALLOC: begin
				if ((scan_end || st_rd == SS_FREE) && out_free) state_nxt = ST_IDLE;
			end
			ST_TICK: begin
				if (tick_done && out_free) state_nxt = ST_IDLE;
			end
		endcase
	end

	// datapath control
	always_comb begin
		push       = 1'b0;
		push_kind  = KIND_ACK;
		push_slot  = '0;
		push_queue = '0;
		push_data  = '0;
		push_last  = 1'b1;
		st_we      = 1'b0;
		st_widx    = req_idx;
		st_wval    = SS_FREE;
		dl_we      = 1'b0;
		info_we    = 1'b0;
		ram_re     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (req_fire && req_ok) begin
					unique case (op)
						OP_FREE: begin
							st_we   = 1'b1;
							st_wval = SS_FREE;
						end
						OP_INIT: begin
							info_we = 1'b1;
						end
						OP_SET_TIMEOUT: begin
							dl_we   = 1'b1;
							st_we   = 1'b1;
							st_wval = SS_ARMED;
						end
						default: begin
						end
					endcase
				end
			end
			ST_ACK: begin
				push      = out_free;
				push_kind = KIND_ACK;
				push_slot = ack_slot_q;
			end
			ST_ALLOC: begin
				if (scan_end) begin
					push      = out_free;
					push_kind = KIND_ALLOC_NONE;
				end else if (st_rd == SS_FREE) begin
					push      = out_free;
					push_kind = KIND_ALLOC_OK;
					push_slot = 5'(scan_idx);
					st_we     = out_free;
					st_widx   = scan_idx;
					st_wval   = SS_ALLOC;
				end
			end
			ST_TICK: begin
				if (tick_done) begin
					// flush the held fire as the final result, or report an empty tick
					push = out_free;
					if (pend_valid_q) begin
						push_kind  = KIND_FIRED;
						push_slot  = 5'(pend_idx_q);
						push_queue = pend_info_q.queue;
						push_data  = pend_info_q.data;
					end else begin
						push_kind = KIND_TICK_IDLE;
					end
				end else begin
					ram_re = adv && !scan_end;
					if (due && adv) begin
						st_we   = 1'b1;
						st_widx = rd_idx_s1;
						st_wval = SS_ALLOC;
						// a newer fire exists, so the held one is not last
						if (pend_valid_q) begin
							push       = 1'b1;
							push_kind  = KIND_FIRED;
							push_slot  = 5'(pend_idx_q);
							push_queue = pend_info_q.queue;
							push_data  = pend_info_q.data;
							push_last  = 1'b0;
						end
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			tick_q       <= '0;
			scan_q       <= '0;
			fire_cnt_q   <= '0;
			pend_valid_q <= 1'b0;
			rd_valid_s1  <= 1'b0;
			rsp_valid_q  <= 1'b0;
			for (int i = 0; i < SLOT_COUNT; i++) begin
				status_q[i] <= SS_FREE;
			end
		end else begin
			state_q <= state_nxt;
			if (st_we) begin
				status_q[st_widx] <= st_wval;
			end
			if (req_fire) begin
				scan_q       <= '0;
				fire_cnt_q   <= '0;
				pend_valid_q <= 1'b0;
				rd_valid_s1  <= 1'b0;
				if (op == OP_TICK) begin
					tick_q <= tick_q + 32'd1;
				end
			end else if (state_q == ST_ALLOC) begin
				if (!scan_end && st_rd != SS_FREE) begin
					scan_q <= scan_q + SCNT_W'(1);
				end
			end else if (state_q == ST_TICK && adv) begin
				rd_valid_s1 <= ram_re;
				if (ram_re) begin
					scan_q <= scan_q + SCNT_W'(1);
				end
				if (due) begin
					fire_cnt_q   <= fire_cnt_q + FCNT_W'(1);
					pend_valid_q <= 1'b1;
				end
			end
			if (push) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			ack_slot_q <= slot;
		end
		if (state_q == ST_TICK && adv) begin
			rd_idx_s1 <= scan_idx;
		end
		if (due && adv) begin
			pend_idx_q  <= rd_idx_s1;
			pend_info_q <= info_rd;
		end
		if (push) begin
			kind_q      <= push_kind;
			slot_out_q  <= push_slot;
			queue_out_q <= push_queue;
			data_out_q  <= push_data;
			last_q      <= push_last;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign kind      = kind_q;
	assign slot_out  = slot_out_q;
	assign queue_out = queue_out_q;
	assign data_out  = data_out_q;
	assign last      = last_q;

`include "timer_slot_pool_unit_assert.svh"

	// an accepted tick advances the counter by exactly one
	`TSP_ASSERT_NEXT(a_tick_inc, req_fire && op == OP_TICK, tick_q == $past(tick_q) + 32'd1)
	// never fire more timers in one tick than the result cap
	`TSP_ASSERT_IMPL(a_fire_cap, state_q == ST_TICK, fire_cnt_q <= FCNT_W'(MAX_RESULTS))
	// slotless results carry zero slot and always close the transaction
	`TSP_ASSERT_IMPL(a_slotless, rsp_valid && (kind == KIND_ALLOC_NONE || kind == KIND_TICK_IDLE),
		slot_out == 5'd0 && last)

endmodule

// ===== design/tsp_ram.sv =====
module tsp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		// hold read data while no read is issued
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== test/timer_slot_pool_checker.sv =====
module timer_slot_pool_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	input  logic        req_ready,
	input  logic [2:0]  op,
	input  logic [4:0]  slot,
	input  logic [1:0]  queue_id,
	input  logic [7:0]  payload,
	input  logic [31:0] delay_ticks,
	input  logic        rsp_valid,
	input  logic        rsp_ready,
	input  logic [2:0]  kind,
	input  logic [4:0]  slot_out,
	input  logic [1:0]  queue_out,
	input  logic [7:0]  data_out,
	input  logic        last,
	output int          fail_count,
	output int          outstanding,
	output int          results_seen,
	output int          timer_expiries,
	output int          widest_tick
);

	import tsp_pkg::*;

	typedef struct {
		kind_t      kind;
		logic [4:0] slot;
		logic [1:0] queue;
		logic [7:0] data;
		logic       last;
	} timer_event_t;

	logic [31:0]  tick_count;
	slot_state_t  slot_state [SLOT_COUNT];
	logic [31:0]  slot_deadline [SLOT_COUNT];
	slot_info_t   slot_info [SLOT_COUNT];
	timer_event_t due_events [$];

	task automatic queue_event(input kind_t k, input int s, input logic [1:0] q,
			input logic [7:0] d, input logic l);
		timer_event_t ev;
		ev.kind  = k;
		ev.slot  = 5'(s);
		ev.queue = q;
		ev.data  = d;
		ev.last  = l;
		due_events.push_back(ev);
	endtask

	// Advance the shadow timer table by one request and queue the results it causes.
	task automatic predict_timer_events(input logic [2:0] req_op, input logic [4:0] req_slot,
			input logic [1:0] req_queue, input logic [7:0] req_data,
			input logic [31:0] req_delay);
		int           i;
		int           fired;
		int           free_slot;
		bit           in_range;
		timer_event_t held;
		in_range  = int'(req_slot) < SLOT_COUNT;
		fired     = 0;
		free_slot = -1;
		case (req_op)
		OP_ALLOC: begin
			for (i = 0; i < SLOT_COUNT; i++)
				if (free_slot < 0 && slot_state[i] == SS_FREE)
					free_slot = i;
			if (free_slot >= 0) begin
				slot_state[free_slot] = SS_ALLOC;
				queue_event(KIND_ALLOC_OK, free_slot, 2'd0, 8'd0, 1'b1);
			end else
				queue_event(KIND_ALLOC_NONE, 0, 2'd0, 8'd0, 1'b1);
		end
		OP_FREE: begin
			if (in_range)
				slot_state[req_slot] = SS_FREE;
			queue_event(KIND_ACK, req_slot, 2'd0, 8'd0, 1'b1);
		end
		OP_INIT: begin
			if (in_range) begin
				// clamp a queue number the pool does not have to its top queue
				slot_info[req_slot].queue = (int'(req_queue) >= QUEUE_COUNT) ?
					2'(QUEUE_COUNT - 1) : req_queue;
				slot_info[req_slot].data = req_data;
			end
			queue_event(KIND_ACK, req_slot, 2'd0, 8'd0, 1'b1);
		end
		OP_SET_TIMEOUT: begin
			if (in_range) begin
				slot_deadline[req_slot] = req_delay + tick_count;
				slot_state[req_slot]    = SS_ARMED;
			end
			queue_event(KIND_ACK, req_slot, 2'd0, 8'd0, 1'b1);
		end
		OP_TICK: begin
			tick_count = tick_count + 32'd1;
			for (i = 0; i < SLOT_COUNT && fired < MAX_RESULTS; i++) begin
				if (slot_state[i] == SS_ARMED && slot_deadline[i] <= tick_count) begin
					slot_state[i] = SS_ALLOC;
					// hold each expiry back one step so the final one can carry last
					if (fired > 0)
						due_events.push_back(held);
					held.kind  = KIND_FIRED;
					held.slot  = 5'(i);
					held.queue = slot_info[i].queue;
					held.data  = slot_info[i].data;
					held.last  = 1'b0;
					fired++;
				end
			end
			if (fired == 0)
				queue_event(KIND_TICK_IDLE, 0, 2'd0, 8'd0, 1'b1);
			else begin
				held.last = 1'b1;
				due_events.push_back(held);
			end
			timer_expiries += fired;
			if (fired > widest_tick)
				widest_tick = fired;
		end
		default: ;
		endcase
	endtask

	task automatic compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			fail_count++;
		end
	endtask

	task automatic check_result();
		timer_event_t want;
		results_seen++;
		if (due_events.size() == 0) begin
			$display({"%0t: unexpected result, expected none, ",
				"got kind %0d slot %0d queue %0d data %0d last %0b"},
				$time, kind, slot_out, queue_out, data_out, last);
			fail_count++;
		end else begin
			want = due_events.pop_front();
			compare_field("kind", 32'(want.kind), 32'(kind));
			compare_field("slot_out", 32'(want.slot), 32'(slot_out));
			compare_field("queue_out", 32'(want.queue), 32'(queue_out));
			compare_field("data_out", 32'(want.data), 32'(data_out));
			compare_field("last", 32'(want.last), 32'(last));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_count = '0;
			for (int i = 0; i < SLOT_COUNT; i++) begin
				slot_state[i]    = SS_FREE;
				slot_deadline[i] = '0;
				slot_info[i]     = '0;
			end
			due_events.delete();
			fail_count     = 0;
			outstanding    = 0;
			results_seen   = 0;
			timer_expiries = 0;
			widest_tick    = 0;
		end else begin
			// results leaving now belong to earlier requests, so check them first
			if (rsp_valid && rsp_ready)
				check_result();
			if (req_valid && req_ready)
				predict_timer_events(op, slot, queue_id, payload, delay_ticks);
			outstanding = due_events.size();
		end
	end

endmodule

// ===== test/testbench.sv =====
module testbench;
	import tsp_pkg::*;

	// Stimulus size, run limit and the quiet time allowed after the last result.
	// A tick walks every slot, so the settle time is sized from the slot count.
	localparam int ITEM_TARGET   = 400;
	localparam int FIRST_STAGE   = 150;
	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int SETTLE_CYCLES = 2 * SLOT_COUNT + 8;
	localparam int LONG_HOLD     = 300;

	logic        clk;
	logic        arst_n;
	logic        req_valid;
	logic        req_ready;
	logic [2:0]  op;
	logic [4:0]  slot;
	logic [1:0]  queue_id;
	logic [7:0]  payload;
	logic [31:0] delay_ticks;
	logic        rsp_valid;
	logic        rsp_ready;
	logic [2:0]  kind;
	logic [4:0]  slot_out;
	logic [1:0]  queue_out;
	logic [7:0]  data_out;
	logic        last;

	// Checker outputs: failures, results still owed, and a few run statistics.
	int fail_count;
	int outstanding;
	int results_seen;
	int timer_expiries;
	int widest_tick;

	int requests_sent = 0;
	int ticks_sent    = 0;
	int gapless_left  = 0;
	int rsp_wait      = 0;
	int rsp_taken     = 0;
	int cycles        = 0;

	// Slots that have had queue and data written; only these may ever be armed,
	// so an expiry never reads slot data that was never stored.
	bit [SLOT_COUNT-1:0] slot_inited = '0;

	timer_slot_pool_unit DUT (.*);

	timer_slot_pool_checker watcher (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Hard stop in case the block hangs on either channel.
	always @(posedge clk) begin
		cycles = cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timed out after %0d cycles with %0d results owed", cycles, outstanding);
			$display("timer_slot_pool_unit regression: fail");
			$finish;
		end
	end

	// Idle draw shared by both sides: zero fairly often, otherwise drawn at random.
	function automatic int idle_draw();
		return ($urandom_range(0, 9) < 3) ? 0 : int'($urandom_range(0, 11));
	endfunction

	// Timeouts: mostly short so timers really expire, some far out, some just
	// below 2^32 so the deadline wraps behind the counter, some fully random.
	function automatic logic [31:0] delay_draw();
		int pick;
		pick = $urandom_range(0, 19);
		if (pick < 12)
			return $urandom_range(0, 4);
		else if (pick < 15)
			return $urandom_range(5, 40);
		else if (pick < 17)
			return 32'hFFFF_FFFF - $urandom_range(0, 3);
		else
			return $urandom;
	endfunction

	// Receiver: drop ready for the drawn number of cycles, then hold it high
	// until the next transaction. Exactly one assignment per falling edge.
	initial begin
		rsp_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (rsp_wait > 0) begin
				rsp_ready <= 1'b0;
				rsp_wait  = rsp_wait - 1;
			end else
				rsp_ready <= 1'b1;
		end
	end

	// Draw the receiver's wait after each result transaction. Twice in the run,
	// back off for a long stretch so the block fills up and stalls its input;
	// keep one window of results free of any stall.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			rsp_taken = rsp_taken + 1;
			if (rsp_taken == 40 || rsp_taken == 260)
				rsp_wait = LONG_HOLD;
			else if (rsp_taken >= 120 && rsp_taken < 180)
				rsp_wait = 0;
			else
				rsp_wait = idle_draw();
		end
	end

	// Offer one request transaction. Enter just after a rising edge; leave at
	// the rising edge that accepted it. Valid stays high across back-to-back
	// items and is only lowered when an idle gap is drawn.
	task automatic offer(input logic [2:0] code, input logic [4:0] target,
			input logic [1:0] dest, input logic [7:0] data, input logic [31:0] delay);
		int gap;
		if (gapless_left > 0) begin
			gap          = 0;
			gapless_left = gapless_left - 1;
		end else
			gap = idle_draw();
		@(negedge clk);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_valid   <= 1'b1;
		op          <= code;
		slot        <= target;
		queue_id    <= dest;
		payload     <= data;
		delay_ticks <= delay;
		do
			@(posedge clk);
		while (!req_ready);
		if (code <= OP_TICK)
			requests_sent = requests_sent + 1;
		if (code == OP_TICK)
			ticks_sent = ticks_sent + 1;
	endtask

	// Fields the operation ignores carry random junk throughout.
	task automatic send_alloc();
		offer(OP_ALLOC, 5'($urandom), 2'($urandom), 8'($urandom), $urandom);
	endtask

	task automatic send_tick();
		offer(OP_TICK, 5'($urandom), 2'($urandom), 8'($urandom), $urandom);
	endtask

	task automatic send_free(input int s);
		offer(OP_FREE, 5'(s), 2'($urandom), 8'($urandom), $urandom);
	endtask

	task automatic send_init(input int s, input logic [1:0] dest, input logic [7:0] data);
		offer(OP_INIT, 5'(s), dest, data, $urandom);
		slot_inited[s] = 1'b1;
	endtask

	// Arm a slot; store queue and data first if the slot never had them.
	task automatic send_arm(input int s, input logic [31:0] delay);
		if (!slot_inited[s])
			send_init(s, 2'($urandom), 8'($urandom));
		offer(OP_SET_TIMEOUT, 5'(s), 2'($urandom), 8'($urandom), delay);
	endtask

	// Opcodes past tick are undefined and must be swallowed without a result.
	task automatic send_stray(input int step);
		offer(OP_TICK + 3'(step), 5'($urandom), 2'($urandom), 8'($urandom), $urandom);
	endtask

	// Park the sender until every owed result has come back.
	task automatic drain();
		@(negedge clk);
		req_valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
	endtask

	// One random step. Most steps are real timer use (store, arm, tick);
	// the rest are bare allocs, frees, lone writes and stray opcodes.
	task automatic random_step();
		int pick;
		int s;
		if (gapless_left == 0 && $urandom_range(0, 24) == 0)
			gapless_left = $urandom_range(10, 30);
		pick = $urandom_range(0, 99);
		s    = $urandom_range(0, SLOT_COUNT - 1);
		if (pick < 35) begin
			send_init(s, 2'($urandom), 8'($urandom));
			send_arm(s, delay_draw());
		end else if (pick < 60)
			repeat ($urandom_range(1, 3)) send_tick();
		else if (pick < 70)
			send_alloc();
		else if (pick < 78)
			send_free(s);
		else if (pick < 83)
			send_init(s, 2'($urandom), 8'($urandom));
		else if (pick < 88)
			send_arm(s, delay_draw());
		else if (pick < 92)
			send_stray($urandom_range(1, 3));
		else if (pick < 96)
			repeat ($urandom_range(2, 6)) send_alloc();
		else begin
			// several timers due on the same tick
			repeat ($urandom_range(3, 8))
				send_arm($urandom_range(0, SLOT_COUNT - 1), $urandom_range(0, 1));
			send_tick();
		end
	endtask

	initial begin
		arst_n      = 1'b0;
		req_valid   = 1'b0;
		op          = OP_ALLOC;
		slot        = '0;
		queue_id    = '0;
		payload     = '0;
		delay_ticks = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: first allocs, queue and data extremes, a timer due on the
		// very next tick, a deadline that wraps behind the counter, an armed
		// free slot, stray opcodes, two expiries on one tick, freeing an armed
		// slot, and alloc reuse of the lowest freed slot.
		send_alloc();
		send_alloc();
		send_init(0, 2'd3, 8'hFF);
		send_init(1, 2'd0, 8'h00);
		send_arm(0, 32'd0);
		send_arm(1, 32'hFFFF_FFFF);
		send_tick();
		send_tick();
		send_init(31, 2'd2, 8'hA5);
		send_arm(31, 32'd1);
		send_arm(0, 32'hFFFF_FFFF);
		send_stray(1);
		send_stray(2);
		send_stray(3);
		send_tick();
		send_free(1);
		send_free(31);
		send_alloc();
		send_init(2, 2'd1, 8'h5A);
		send_arm(2, 32'h8000_0000);
		send_tick();
		send_free(2);
		drain();

		while (requests_sent < FIRST_STAGE)
			random_step();

		// Arm every slot for the next tick: one tick, a full table of expiries.
		for (int s = 0; s < SLOT_COUNT; s++) begin
			send_init(s, 2'($urandom), 8'($urandom));
			send_arm(s, 32'd1);
		end
		send_tick();
		send_tick();
		drain();

		// Every slot is allocated now: exhaust, release two, refill past the top.
		send_alloc();
		send_free(SLOT_COUNT - 1);
		send_free(7);
		repeat (3) send_alloc();

		while (requests_sent < ITEM_TARGET)
			random_step();

		drain();
		repeat (SETTLE_CYCLES) @(negedge clk);

		$display("covered %0d requests with %0d ticks; checked %0d results,",
			requests_sent, ticks_sent, results_seen);
		$display("including %0d timer expiries, at most %0d on a single tick",
			timer_expiries, widest_tick);
		if (fail_count == 0)
			$display("timer_slot_pool_unit regression: pass");
		else
			$display("timer_slot_pool_unit regression: fail");
		$finish;
	end

endmodule
